// ===== sv/rbt_pkg.sv =====
package rbt_pkg;

   // request codes
   localparam logic [1:0] REQ_FAILURE = 2'd0;
   localparam logic [1:0] REQ_RESET   = 2'd1;
   localparam logic [1:0] REQ_QUERY   = 2'd2;

   // backoff modes
   localparam logic [1:0] MODE_FIXED       = 2'd0;
   localparam logic [1:0] MODE_LINEAR      = 2'd1;
   localparam logic [1:0] MODE_EXPONENTIAL = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MAX_RETRIES   = 2'd0;
   localparam logic [1:0] CSR_BASE_DELAY_MS = 2'd1;
   localparam logic [1:0] CSR_BACKOFF_MODE  = 2'd2;

   localparam logic [3:0]  MAX_RETRIES_RESET  = 4'd3;
   localparam logic [25:0] BASE_DELAY_RESET   = 26'd2000;
   localparam logic [1:0]  BACKOFF_MODE_RESET = MODE_EXPONENTIAL;
   localparam logic [3:0]  EXP_SHIFT_CAP      = 4'd6;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic        retry_granted;
      logic        retry_due;
      logic [3:0]  retries_used;
      logic [31:0] delay_ms;
      logic [31:0] next_retry_ms;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  reg_index;
      logic [25:0] wdata;
   } csr_payload_type;

endpackage

// ===== sv/rbt_chan_if.sv =====
interface rbt_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/retry_backoff_timer_core.sv =====
// Retry budget and backoff timer. Each request transaction is a failure report, a retry-state
// reset or a query, stamped with a free-running 32-bit millisecond time; each one produces
// exactly one response carrying the grant flag, whether a retry is due now, the used count,
// the current backoff delay (fixed, linear or exponential with the shift capped at six) and
// the next retry time, all as they stand after the request. One request is accepted every
// clock unless a stalled response backs up into the input register: a request sits in the input
// register while its state update and response are computed, and the response register loads
// from it once the response register is free, and the response is offered from there. The input
// register absorbs one request while a response is stalled. Registers are
// written through the csr channel, which is always ready and must only be used while idle.
module retry_backoff_timer_core #(
   parameter int RETRY_LIMIT = 10
) (
   input  logic         clock,
   input  logic         reset,
   rbt_chan_if.sink     req_ch,
   rbt_chan_if.source   rsp_ch,
   rbt_chan_if.sink     csr_ch
);
   import rbt_pkg::*;

   localparam logic [3:0] LimitCode = 4'(RETRY_LIMIT);

   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_req_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [3:0]      used_ff, used_in;
   logic [31:0]     last_ff, last_in;
   logic [3:0]      max_ff;
   logic [25:0]     base_ff;
   logic [1:0]      mode_ff;

   logic            s1_adv;
   logic            rsp_free;
   logic            req_acc;
   logic            csr_acc;
   logic [3:0]      step_used;
   logic [31:0]     step_last;
   logic            step_granted;
   logic [4:0]      used_plus;
   logic [30:0]     lin_prod;
   logic [2:0]      exp_shift;
   logic [31:0]     delay;
   logic [31:0]     elapsed;

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && rsp_free;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_acc      = csr_ch.valid;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // state after the step
   always_comb begin
      step_used    = used_ff;
      step_last    = last_ff;
      step_granted = 1'b0;
      case (s1_req_ff.req_type)
         REQ_FAILURE: begin
            step_last = s1_req_ff.now_ms;
            if (used_ff < max_ff) begin
               step_used    = used_ff + 4'd1;
               step_granted = 1'b1;
            end
         end
         REQ_RESET: begin
            step_used = '0;
            step_last = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      used_plus = {1'b0, step_used} + 5'd1;
      lin_prod  = 31'(base_ff) * 31'(used_plus);
      exp_shift = (step_used > EXP_SHIFT_CAP) ? EXP_SHIFT_CAP[2:0] : step_used[2:0];
      case (mode_ff)
         MODE_LINEAR:      delay = {1'b0, lin_prod};
         MODE_EXPONENTIAL: delay = {6'd0, base_ff} << exp_shift;
         default:          delay = {6'd0, base_ff};
      endcase
      elapsed = s1_req_ff.now_ms - step_last;
   end

   always_comb begin
      rsp_data_in.retry_granted = step_granted;
      rsp_data_in.retry_due     = (step_used != 4'd0) && (step_used <= max_ff)
                                  && (elapsed >= delay);
      rsp_data_in.retries_used  = step_used;
      rsp_data_in.delay_ms      = delay;
      rsp_data_in.next_retry_ms = step_last + delay;

      used_in      = s1_adv ? step_used : used_ff;
      last_in      = s1_adv ? step_last : last_ff;
      s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         last_ff      <= '0;
         max_ff       <= MAX_RETRIES_RESET;
         base_ff      <= BASE_DELAY_RESET;
         mode_ff      <= BACKOFF_MODE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         last_ff      <= last_in;
         if (csr_acc) begin
            unique case (csr_ch.payload.reg_index)
               CSR_MAX_RETRIES: begin
                  // saturate at the retry limit
                  max_ff <= (csr_ch.payload.wdata[3:0] > LimitCode) ?
                            LimitCode : csr_ch.payload.wdata[3:0];
               end
               CSR_BASE_DELAY_MS: base_ff <= csr_ch.payload.wdata;
               CSR_BACKOFF_MODE:  mode_ff <= csr_ch.payload.wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_req_ff <= req_ch.payload;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_used_in_limit: assert property (@(posedge clock) disable iff (reset)
      used_ff <= LimitCode)
      else $error("used count above retry limit");

   a_max_in_limit: assert property (@(posedge clock) disable iff (reset)
      max_ff <= LimitCode)
      else $error("retry budget above retry limit");

   a_failure_time: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_req_ff.req_type == REQ_FAILURE |=> last_ff == $past(s1_req_ff.now_ms))
      else $error("failure time not recorded");

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_req_ff.req_type == REQ_RESET |=> used_ff == 4'd0 && last_ff == 32'd0)
      else $error("retry state not cleared");

   a_grant_counts: assert property (@(posedge clock) disable iff (reset)
      s1_adv && step_granted |=> used_ff == $past(used_ff) + 4'd1 && rsp_valid_ff)
      else $error("grant without count update");

endmodule
